/* hw/rtl/bsc_pkg.sv */
package bsc_pkg;

  localparam int CoefW   = 16;
  localparam int RawW    = 24;
  localparam int TempW   = 19;
  localparam int PresW   = 20;
  localparam int CfgIdxW = 3;
  localparam int Latency = 10;

  localparam logic signed [TempW-1:0] TEMP_REF     = 19'sd2000;
  localparam logic signed [TempW-1:0] TEMP_COLD    = -19'sd1500;
  localparam logic signed [TempW-1:0] TEMP_LOW_LIM = -19'sd4000;
  localparam logic signed [TempW-1:0] TEMP_HI_LIM  = 19'sd8500;
  localparam logic signed [PresW-1:0] PRES_MAX     = 20'sd524287;
  localparam logic signed [PresW-1:0] PRES_MIN     = -20'sd524288;

  localparam logic [CoefW-1:0] C1_RESET = 16'd40127;
  localparam logic [CoefW-1:0] C2_RESET = 16'd36924;
  localparam logic [CoefW-1:0] C3_RESET = 16'd23317;
  localparam logic [CoefW-1:0] C4_RESET = 16'd23282;
  localparam logic [CoefW-1:0] C5_RESET = 16'd33464;
  localparam logic [CoefW-1:0] C6_RESET = 16'd28312;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SENS      = 3'd0,
    REG_OFFSET    = 3'd1,
    REG_SENS_TC   = 3'd2,
    REG_OFFSET_TC = 3'd3,
    REG_REF_TEMP  = 3'd4,
    REG_TEMP_SLP  = 3'd5
  } bsc_reg_idx_t;

  typedef struct packed {
    logic [CoefW-1:0] c1;
    logic [CoefW-1:0] c2;
    logic [CoefW-1:0] c3;
    logic [CoefW-1:0] c4;
    logic [CoefW-1:0] c5;
    logic [CoefW-1:0] c6;
  } bsc_coef_t;

endpackage

/* hw/rtl/bsc_coef_regs.sv */
module bsc_coef_regs
  import bsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [CfgIdxW-1:0] wr_index,
  input  logic [CoefW-1:0]   wr_data,
  output bsc_coef_t          coef
);

  bsc_coef_t coef_r;
  bsc_coef_t coef_nxt;

  always_comb begin
    coef_nxt = coef_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_SENS:      coef_nxt.c1 = wr_data;
        REG_OFFSET:    coef_nxt.c2 = wr_data;
        REG_SENS_TC:   coef_nxt.c3 = wr_data;
        REG_OFFSET_TC: coef_nxt.c4 = wr_data;
        REG_REF_TEMP:  coef_nxt.c5 = wr_data;
        REG_TEMP_SLP:  coef_nxt.c6 = wr_data;
        default:       coef_nxt = coef_r; // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.c1 <= C1_RESET;
      coef_r.c2 <= C2_RESET;
      coef_r.c3 <= C3_RESET;
      coef_r.c4 <= C4_RESET;
      coef_r.c5 <= C5_RESET;
      coef_r.c6 <= C6_RESET;
    end else begin
      coef_r <= coef_nxt;
    end
  end

  assign coef = coef_r;

endmodule

/* hw/rtl/baro_sensor_compensation_unit.sv */
// Barometric sensor compensation: raw pressure and temperature conversions in,
// compensated temperature (0.01 C) and pressure (Pa) out, with the usual
// second-order correction below 20 C and a stronger one below -15 C.
// Input: a transaction is taken on each rising edge with start high and busy
// low. busy stays low, so a new conversion pair may be offered every cycle.
// Output: out_valid strobes for one cycle with the result fields; the
// receiver cannot stall, so every result must be taken in its cycle.
// Throughput is one transaction per cycle, set by a ten-stage pipeline
// with at most one multiplier (or partial product) per path; each result
// leaves the output registers of the last stage together with out_valid.
// Configuration: six calibration words written through cfg_valid/cfg_ready
// (always ready), index 0..5; other indexes are ignored. Write only while no
// transaction is in flight.
// Reset (synchronous, rst_n low) restores the factory calibration words and
// empties the pipeline; no result is produced for work in flight at reset.
module baro_sensor_compensation_unit
  import bsc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [RawW-1:0]         in_raw_pressure,
  input  logic [RawW-1:0]         in_raw_temperature,
  output logic                    out_valid,
  output logic signed [TempW-1:0] out_temp_centideg,
  output logic signed [PresW-1:0] out_pressure_pa,
  output logic                    out_out_of_range,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CfgIdxW-1:0]      cfg_index,
  input  logic [CoefW-1:0]        cfg_data
);

  bsc_coef_t coef;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  bsc_coef_regs u_coef_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .coef     (coef)
  );

  logic [Latency-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[Latency-2:0], start && !busy};
    end
  end

  // Stage 1: temperature difference
  logic signed [24:0] s1_dt_r;
  logic [RawW-1:0]    s1_d1_r;

  always_ff @(posedge clk) begin
    s1_dt_r <= $signed({1'b0, in_raw_temperature}) - $signed({1'b0, coef.c5, 8'b0});
    s1_d1_r <= in_raw_pressure;
  end

  // Stage 2: three coefficient products
  logic signed [41:0] s2_p6_r, s2_p4_r, s2_p3_r;
  logic [RawW-1:0]    s2_d1_r;

  always_ff @(posedge clk) begin
    s2_p6_r <= s1_dt_r * $signed({1'b0, coef.c6});
    s2_p4_r <= s1_dt_r * $signed({1'b0, coef.c4});
    s2_p3_r <= s1_dt_r * $signed({1'b0, coef.c3});
    s2_d1_r <= s1_d1_r;
  end

  // Stage 3: first-order temperature, offset and sensitivity
  logic signed [TempW-1:0] s3_temp_r;
  logic signed [35:0]      s3_off1_r;
  logic signed [34:0]      s3_sens1_r;
  logic [RawW-1:0]         s3_d1_r;

  always_ff @(posedge clk) begin
    s3_temp_r  <= $signed(s2_p6_r[41:23]) + TEMP_REF;
    s3_off1_r  <= $signed({4'b0, coef.c2, 16'b0}) + $signed(s2_p4_r[41:7]);
    s3_sens1_r <= $signed({4'b0, coef.c1, 15'b0}) + $signed(s2_p3_r[41:8]);
    s3_d1_r    <= s2_d1_r;
  end

  // Stage 4: squares of the distances from the two thresholds
  logic signed [19:0] s4_a, s4_b;
  logic signed [39:0] s4_asq, s4_bsq;
  logic [34:0]        s4_d_r, s4_e_r;
  logic               s4_cold_r, s4_vcold_r;
  logic signed [TempW-1:0] s4_temp_r;
  logic signed [35:0] s4_off1_r;
  logic signed [34:0] s4_sens1_r;
  logic [RawW-1:0]    s4_d1_r;

  assign s4_a   = s3_temp_r - TEMP_REF;
  assign s4_b   = s3_temp_r - TEMP_COLD;
  assign s4_asq = s4_a * s4_a;
  assign s4_bsq = s4_b * s4_b;

  always_ff @(posedge clk) begin
    s4_d_r     <= s4_asq[34:0];
    s4_e_r     <= s4_bsq[34:0];
    s4_cold_r  <= s3_temp_r < TEMP_REF;
    s4_vcold_r <= s3_temp_r < TEMP_COLD;
    s4_temp_r  <= s3_temp_r;
    s4_off1_r  <= s3_off1_r;
    s4_sens1_r <= s3_sens1_r;
    s4_d1_r    <= s3_d1_r;
  end

  // Stage 5: second-order offset and sensitivity terms
  logic [39:0] s5_d5, s5_e7, s5_e11, s5_off2, s5_sens2;
  logic [39:0] s5_off2_r, s5_sens2_r;
  logic signed [TempW-1:0] s5_temp_r;
  logic signed [35:0] s5_off1_r;
  logic signed [34:0] s5_sens1_r;
  logic [RawW-1:0]    s5_d1_r;

  assign s5_d5  = {5'b0, s4_d_r} + {3'b0, s4_d_r, 2'b0};
  assign s5_e7  = {2'b0, s4_e_r, 3'b0} - {5'b0, s4_e_r};
  assign s5_e11 = {2'b0, s4_e_r, 3'b0} + {4'b0, s4_e_r, 1'b0} + {5'b0, s4_e_r};

  always_comb begin
    s5_off2  = '0;
    s5_sens2 = '0;
    if (s4_cold_r) begin
      s5_off2  = s5_d5 >> 1;
      s5_sens2 = s5_d5 >> 2;
      if (s4_vcold_r) begin
        s5_off2  = (s5_d5 >> 1) + s5_e7;
        s5_sens2 = (s5_d5 >> 2) + (s5_e11 >> 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    s5_off2_r  <= s5_off2;
    s5_sens2_r <= s5_sens2;
    s5_temp_r  <= s4_temp_r;
    s5_off1_r  <= s4_off1_r;
    s5_sens1_r <= s4_sens1_r;
    s5_d1_r    <= s4_d1_r;
  end

  // Stage 6: corrected offset and sensitivity
  logic signed [41:0] s6_off_r, s6_sens_r;
  logic signed [TempW-1:0] s6_temp_r;
  logic [RawW-1:0]    s6_d1_r;

  always_ff @(posedge clk) begin
    s6_off_r  <= s5_off1_r - $signed({2'b0, s5_off2_r});
    s6_sens_r <= s5_sens1_r - $signed({2'b0, s5_sens2_r});
    s6_temp_r <= s5_temp_r;
    s6_d1_r   <= s5_d1_r;
  end

  // Stage 7: split D1 * SENS into two partial products
  logic [43:0]        s7_lo_r;
  logic signed [46:0] s7_hi_r;
  logic signed [41:0] s7_off_r;
  logic signed [TempW-1:0] s7_temp_r;

  always_ff @(posedge clk) begin
    s7_lo_r   <= s6_d1_r * s6_sens_r[19:0];
    s7_hi_r   <= $signed(s6_sens_r[41:20]) * $signed({1'b0, s6_d1_r});
    s7_off_r  <= s6_off_r;
    s7_temp_r <= s6_temp_r;
  end

  // Stage 8: recombine
  logic signed [66:0] s8_full_r;
  logic signed [41:0] s8_off_r;
  logic signed [TempW-1:0] s8_temp_r;

  always_ff @(posedge clk) begin
    s8_full_r <= (s7_hi_r <<< 20) + $signed({23'b0, s7_lo_r});
    s8_off_r  <= s7_off_r;
    s8_temp_r <= s7_temp_r;
  end

  // Stage 9: scale and remove offset
  logic signed [46:0] s9_x_r;
  logic signed [TempW-1:0] s9_temp_r;

  always_ff @(posedge clk) begin
    s9_x_r    <= $signed(s8_full_r[66:21]) - s8_off_r;
    s9_temp_r <= s8_temp_r;
  end

  // Stage 10: final shift, clamp and range flag
  logic signed [31:0]      s10_q;
  logic signed [PresW-1:0] s10_pres;
  logic signed [TempW-1:0] out_temp_r;
  logic signed [PresW-1:0] out_pres_r;
  logic                    out_oor_r;

  assign s10_q = $signed(s9_x_r[46:15]);

  always_comb begin
    s10_pres = s10_q[PresW-1:0];
    if (s10_q > PRES_MAX) begin
      s10_pres = PRES_MAX;
    end else if (s10_q < PRES_MIN) begin
      s10_pres = PRES_MIN;
    end
  end

  always_ff @(posedge clk) begin
    out_temp_r <= s9_temp_r;
    out_pres_r <= s10_pres;
    out_oor_r  <= (s9_temp_r < TEMP_LOW_LIM) || (s9_temp_r > TEMP_HI_LIM);
  end

  assign out_valid         = vld_r[Latency-1];
  assign out_temp_centideg = out_temp_r;
  assign out_pressure_pa   = out_pres_r;
  assign out_out_of_range  = out_oor_r;

`ifndef ASSERT_OFF
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##10 out_valid)
    else $error("accepted transaction produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##10 !out_valid)
    else $error("result without an accepted transaction");

  a_range_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_out_of_range ==
      ((out_temp_centideg < TEMP_LOW_LIM) || (out_temp_centideg > TEMP_HI_LIM))))
    else $error("range flag disagrees with temperature");
`endif

endmodule

/* tb/bsc_checker.sv */
`timescale 1ns / 1ps

module bsc_checker
  import bsc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    busy,
  input  logic [RawW-1:0]         in_raw_pressure,
  input  logic [RawW-1:0]         in_raw_temperature,
  input  logic                    out_valid,
  input  logic signed [TempW-1:0] out_temp_centideg,
  input  logic signed [PresW-1:0] out_pressure_pa,
  input  logic                    out_out_of_range,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CfgIdxW-1:0]      cfg_index,
  input  logic [CoefW-1:0]        cfg_data,
  output int                      mismatches,
  output int                      outstanding
);

  typedef struct packed {
    logic [RawW-1:0]         raw_p;
    logic [RawW-1:0]         raw_t;
    logic signed [TempW-1:0] temp;
    logic signed [PresW-1:0] pres;
    logic                    oor;
  } reading_t;

  bsc_coef_t calib;
  reading_t  pending_readings[$];
  reading_t  want;
  int        fault_count = 0;

  function automatic reading_t compensate_reading(input bsc_coef_t k,
                                                  input logic [RawW-1:0] d1_raw,
                                                  input logic [RawW-1:0] d2_raw);
    longint c1, c2, c3, c4, c5, c6;
    longint d1, dt, off, sens, temp, delta, sq, p;
    reading_t r;
    c1 = k.c1;
    c2 = k.c2;
    c3 = k.c3;
    c4 = k.c4;
    c5 = k.c5;
    c6 = k.c6;
    d1 = d1_raw;
    dt = d2_raw;
    dt = dt - (c5 <<< 8);
    off  = (c2 <<< 16) + ((dt * c4) >>> 7);
    sens = (c1 <<< 15) + ((dt * c3) >>> 8);
    temp = longint'(TEMP_REF) + ((dt * c6) >>> 23);
    // second-order terms; squares fit easily in 64 bits
    if (temp < longint'(TEMP_REF)) begin
      delta = temp - longint'(TEMP_REF);
      sq = delta * delta;
      off  = off - ((5 * sq) >>> 1);
      sens = sens - ((5 * sq) >>> 2);
      if (temp < longint'(TEMP_COLD)) begin
        delta = temp - longint'(TEMP_COLD);
        sq = delta * delta;
        off  = off - 7 * sq;
        sens = sens - ((11 * sq) >>> 1);
      end
    end
    p = (((d1 * sens) >>> 21) - off) >>> 15;
    if (p > longint'(PRES_MAX)) p = PRES_MAX;
    if (p < longint'(PRES_MIN)) p = PRES_MIN;
    r.raw_p = d1_raw;
    r.raw_t = d2_raw;
    r.temp  = temp[TempW-1:0];
    r.pres  = p[PresW-1:0];
    r.oor   = (temp < longint'(TEMP_LOW_LIM)) || (temp > longint'(TEMP_HI_LIM));
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      calib = '{c1: C1_RESET, c2: C2_RESET, c3: C3_RESET,
                c4: C4_RESET, c5: C5_RESET, c6: C6_RESET};
      pending_readings.delete();
    end else begin
      if (out_valid) begin
        if (pending_readings.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("%0t: result with no transaction waiting: temp=%0d pres=%0d oor=%0b",
                     $time, out_temp_centideg, out_pressure_pa, out_out_of_range);
        end else begin
          want = pending_readings.pop_front();
          if (out_temp_centideg !== want.temp || out_pressure_pa !== want.pres ||
              out_out_of_range !== want.oor) begin
            fault_count++;
            if (fault_count <= 10)
              $display("%0t: mismatch d1=%0d d2=%0d: want %0d/%0d/%0b got %0d/%0d/%0b",
                       $time, want.raw_p, want.raw_t, want.temp, want.pres, want.oor,
                       out_temp_centideg, out_pressure_pa, out_out_of_range);
          end
        end
      end
      if (start && !busy)
        pending_readings.push_back(compensate_reading(calib, in_raw_pressure,
                                                      in_raw_temperature));
      // unknown indexes leave the calibration untouched
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SENS:      calib.c1 = cfg_data;
          REG_OFFSET:    calib.c2 = cfg_data;
          REG_SENS_TC:   calib.c3 = cfg_data;
          REG_OFFSET_TC: calib.c4 = cfg_data;
          REG_REF_TEMP:  calib.c5 = cfg_data;
          REG_TEMP_SLP:  calib.c6 = cfg_data;
          default: ;
        endcase
      end
    end
    mismatches  <= fault_count;
    outstanding <= pending_readings.size();
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import bsc_pkg::*;

  localparam logic [CfgIdxW-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_SPARE_B = 3'd7;
  localparam logic [RawW-1:0]    RAW_MAX     = '1;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [RawW-1:0]         in_raw_pressure = '0;
  logic [RawW-1:0]         in_raw_temperature = '0;
  logic                    out_valid;
  logic signed [TempW-1:0] out_temp_centideg;
  logic signed [PresW-1:0] out_pressure_pa;
  logic                    out_out_of_range;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CfgIdxW-1:0]      cfg_index = '0;
  logic [CoefW-1:0]        cfg_data = '0;
  int                      mismatches;
  int                      outstanding;
  bit                      gaps_on = 1'b1;
  // current reference word, used to aim raw temperatures near the bend
  logic [CoefW-1:0]        ref_word = C5_RESET;

  always #6 clk = ~clk;

  baro_sensor_compensation_unit u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_raw_pressure    (in_raw_pressure),
    .in_raw_temperature (in_raw_temperature),
    .out_valid          (out_valid),
    .out_temp_centideg  (out_temp_centideg),
    .out_pressure_pa    (out_pressure_pa),
    .out_out_of_range   (out_out_of_range),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  bsc_checker u_chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_raw_pressure    (in_raw_pressure),
    .in_raw_temperature (in_raw_temperature),
    .out_valid          (out_valid),
    .out_temp_centideg  (out_temp_centideg),
    .out_pressure_pa    (out_pressure_pa),
    .out_out_of_range   (out_out_of_range),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .mismatches         (mismatches),
    .outstanding        (outstanding)
  );

  // raw temperature word that lands exactly on a given temperature with
  // the factory calibration
  function automatic logic [RawW-1:0] raw_temp_for(input longint target);
    longint num, slope, dt, base;
    num   = (target - longint'(TEMP_REF)) <<< 23;
    slope = C6_RESET;
    base  = C5_RESET;
    dt    = num / slope;
    if (dt * slope < num) dt++;
    dt = dt + (base <<< 8);
    return dt[RawW-1:0];
  endfunction

  task automatic send_reading(input logic [RawW-1:0] p, input logic [RawW-1:0] t);
    while (gaps_on && $urandom_range(99) < 6) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start              <= 1'b1;
    in_raw_pressure    <= p;
    in_raw_temperature <= t;
    do @(posedge clk); while (busy);
  endtask

  // drop start and hold until every transaction has come back
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_coef(input logic [CfgIdxW-1:0] idx, input logic [CoefW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_coefs(input bsc_coef_t c, input bit with_spare);
    if (with_spare) begin
      write_coef(REG_SPARE_A, CoefW'($urandom));
      write_coef(REG_SPARE_B, CoefW'($urandom));
    end
    write_coef(REG_SENS,      c.c1);
    write_coef(REG_OFFSET,    c.c2);
    write_coef(REG_SENS_TC,   c.c3);
    write_coef(REG_OFFSET_TC, c.c4);
    write_coef(REG_REF_TEMP,  c.c5);
    write_coef(REG_TEMP_SLP,  c.c6);
    cfg_valid <= 1'b0;
    ref_word = c.c5;
  endtask

  task automatic run_random(input int count, input int pause_at);
    logic [RawW-1:0] p, t;
    longint near, jitter;
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) wait_idle();
      case ($urandom_range(9))
        0:       p = '0;
        1:       p = RAW_MAX;
        default: p = RawW'($urandom);
      endcase
      // half the temperatures sit around the reference, where the bends are
      if ($urandom_range(1) == 0) begin
        t = RawW'($urandom);
      end else begin
        jitter = $urandom_range(4194304);
        near   = ref_word;
        near   = (near <<< 8) + jitter - 2097152;
        if (near < 0) near = 0;
        if (near > longint'(RAW_MAX)) near = RAW_MAX;
        t = near[RawW-1:0];
      end
      send_reading(p, t);
    end
    wait_idle();
  endtask

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    bsc_coef_t coefs;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // factory calibration: corners and the temperature thresholds
    send_reading('0, '0);
    send_reading(RAW_MAX, RAW_MAX);
    send_reading('0, RAW_MAX);
    send_reading(RAW_MAX, '0);
    send_reading(RAW_MAX, raw_temp_for(-4001));
    send_reading('0, raw_temp_for(-4000));
    send_reading(RawW'($urandom), raw_temp_for(-1501));
    send_reading(RAW_MAX, raw_temp_for(-1500));
    send_reading(RawW'($urandom), raw_temp_for(1999));
    send_reading(RawW'($urandom), raw_temp_for(2000));
    send_reading(RAW_MAX, raw_temp_for(8500));
    send_reading('0, raw_temp_for(8501));
    wait_idle();

    // all words at maximum drive the pressure onto both rails
    program_coefs('1, 1'b1);
    send_reading('0, '0);
    send_reading(RAW_MAX, '0);
    send_reading('0, RAW_MAX);
    send_reading(RAW_MAX, RAW_MAX);
    run_random(250, -1);

    program_coefs('0, 1'b0);
    run_random(200, -1);

    for (int ph = 0; ph < 4; ph++) begin
      coefs = {$urandom, $urandom, $urandom};
      program_coefs(coefs, ph == 0);
      gaps_on = (ph != 1);
      run_random(250, (ph == 2) ? 120 : -1);
    end
    gaps_on = 1'b1;

    program_coefs('{c1: C1_RESET, c2: C2_RESET, c3: C3_RESET,
                    c4: C4_RESET, c5: C5_RESET, c6: C6_RESET}, 1'b0);
    run_random(250, -1);

    repeat (Latency + 4) @(posedge clk);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/bsc_pkg.sv
hw/rtl/bsc_coef_regs.sv
hw/rtl/baro_sensor_compensation_unit.sv
tb/bsc_checker.sv
tb/tb.sv
